// ----- src/i2cms_pkg.sv -----
// Shared types and constants for the I2C master message sequencer.
// No dependencies; imported by i2cms_desc_store and the top level.
package i2cms_pkg;

  localparam int MAX_MESSAGES = 16;
  localparam int IDX_W        = $clog2(MAX_MESSAGES);
  localparam int CNT_W        = $clog2(MAX_MESSAGES + 1);

  // Request action codes.
  localparam logic [2:0] ACT_LOAD       = 3'd0;
  localparam logic [2:0] ACT_START      = 3'd1;
  localparam logic [2:0] ACT_START_SENT = 3'd2;
  localparam logic [2:0] ACT_ADDR_SENT  = 3'd3;
  localparam logic [2:0] ACT_TX_EMPTY   = 3'd4;
  localparam logic [2:0] ACT_RX_BYTE    = 3'd5;
  localparam logic [2:0] ACT_BUS_ERROR  = 3'd6;

  // Command codes toward the I2C core.
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_ADDR  = 2'd1;
  localparam logic [1:0] CMD_SEND  = 2'd2;
  localparam logic [1:0] CMD_STORE = 2'd3;

  typedef struct packed {
    logic        acklast;
    logic        nostart;
    logic        read;
    logic [15:0] length;
  } desc_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  desc_index;
    logic [15:0] desc_length;
    logic        desc_read;
    logic        desc_nostart;
    logic        desc_acklast;
    logic [6:0]  target_address;
    logic [4:0]  message_count;
    logic [7:0]  rx_byte;
  } req_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  data_byte;
    logic [3:0]  message_index;
    logic [15:0] byte_offset;
    logic        ack_update;
    logic        ack_enable;
    logic        gen_start;
    logic        gen_stop;
    logic        transfer_done;
    logic        transfer_failed;
    logic        start_rejected;
  } rsp_t;

  // Control from the sequencer to the descriptor store.
  typedef struct packed {
    logic             load;
    logic [3:0]       load_index;
    desc_t            load_desc;
    logic             restart;
    logic             advance;
    logic [CNT_W-1:0] msg;
  } desc_ctl_t;

endpackage

// ----- src/i2cms_desc_store.sv -----
// Descriptor table plus a three-entry window (current, next, one after).
// Depends on i2cms_pkg.
module i2cms_desc_store (
  input  logic                  clk,
  input  i2cms_pkg::desc_ctl_t  ctl,
  output i2cms_pkg::desc_t      cur,
  output i2cms_pkg::desc_t      nxt,
  output i2cms_pkg::desc_t      nx2
);
  import i2cms_pkg::*;

  localparam int OFS_W = CNT_W + 1;

  desc_t table_mem [MAX_MESSAGES];

  logic [OFS_W-1:0] msg_w;
  logic [OFS_W-1:0] load_w;

  // Out-of-range slots read as an empty descriptor.
  function automatic desc_t slot_rd(input logic [OFS_W-1:0] i);
    desc_t r;
    r = '0;
    if (i < OFS_W'(MAX_MESSAGES)) begin
      r = table_mem[i[IDX_W-1:0]];
    end
    return r;
  endfunction

  assign msg_w  = OFS_W'(ctl.msg);
  assign load_w = OFS_W'(ctl.load_index);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      table_mem[ctl.load_index[IDX_W-1:0]] <= ctl.load_desc;
    end
  end

  // The window shadows the table so the sequencer sees three slots at once;
  // a load that hits a slot in the window refreshes that copy too.
  always_ff @(posedge clk) begin
    if (ctl.restart) begin
      cur <= slot_rd(OFS_W'(0));
      nxt <= slot_rd(OFS_W'(1));
      nx2 <= slot_rd(OFS_W'(2));
    end else if (ctl.advance) begin
      cur <= nxt;
      nxt <= nx2;
      nx2 <= slot_rd(msg_w + OFS_W'(3));
    end else if (ctl.load) begin
      if (load_w == msg_w) begin
        cur <= ctl.load_desc;
      end
      if (load_w == msg_w + OFS_W'(1)) begin
        nxt <= ctl.load_desc;
      end
      if (load_w == msg_w + OFS_W'(2)) begin
        nx2 <= ctl.load_desc;
      end
    end
  end

endmodule

// ----- src/i2c_master_message_sequencer_core.sv -----
// Top level of the I2C master message sequencer: request register, command
// logic, sequencing state and response register. Depends on i2cms_pkg and
// i2cms_desc_store.
//
//   channel  signals                      moves
//   req      req_valid, req_ready, req    loads, starts and bus events
//   rsp      rsp_valid, rsp_ready, rsp    one response per request
//
// An accepted request is held in the request register; its response is
// loaded into the response register when the response channel can advance.
// A new request can be accepted every cycle while the response is not
// stalled; the rate is set by the single pass through the command logic.
// While a response is stalled, one more request is held in the request
// register before req_ready drops.
// Reset clears the sequencing state and both valid flags; descriptors are
// undefined until loaded.
module i2c_master_message_sequencer_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  i2cms_pkg::req_t  req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output i2cms_pkg::rsp_t  rsp
);
  import i2cms_pkg::*;

  localparam int OFS_W = CNT_W + 1;

  req_t             held;
  logic             held_valid;
  logic             adv;
  logic             go;

  logic [6:0]       target_reg;
  logic [CNT_W-1:0] count_reg;
  logic [CNT_W-1:0] current_message;
  logic [15:0]      current_offset;
  logic             busy;

  logic [6:0]       target_reg_next;
  logic [CNT_W-1:0] count_reg_next;
  logic [CNT_W-1:0] current_message_next;
  logic [15:0]      current_offset_next;
  logic             busy_next;
  rsp_t             rsp_next;

  desc_ctl_t        ctl;
  desc_t            cur;
  desc_t            nxt;
  desc_t            nx2;

  logic [OFS_W-1:0] cm_w;
  logic [OFS_W-1:0] cnt_w;
  logic             more_msgs;
  logic [15:0]      off_bumped;

  i2cms_desc_store u_store (
    .clk (clk),
    .ctl (ctl),
    .cur (cur),
    .nxt (nxt),
    .nx2 (nx2)
  );

  function automatic logic ack_rule(input desc_t d, input desc_t nd,
                                    input logic [15:0] off,
                                    input logic [OFS_W-1:0] cm,
                                    input logic [OFS_W-1:0] cnt);
    logic r;
    r = d.acklast
        || ({1'b0, off} + 17'd1 < {1'b0, d.length})
        || ((cnt > cm + OFS_W'(1)) && (nd.read || nd.nostart));
    return r;
  endfunction

  assign adv       = !rsp_valid || rsp_ready;
  assign req_ready = !held_valid || adv;
  assign go        = held_valid && adv;

  assign cm_w       = OFS_W'(current_message);
  assign cnt_w      = OFS_W'(count_reg);
  assign more_msgs  = (cm_w + OFS_W'(1)) < cnt_w;
  assign off_bumped = (current_offset != 16'hFFFF) ? current_offset + 16'd1
                                                   : current_offset;

  always_comb begin
    target_reg_next      = target_reg;
    count_reg_next       = count_reg;
    current_message_next = current_message;
    current_offset_next  = current_offset;
    busy_next            = busy;
    rsp_next             = '0;
    ctl                  = '0;
    ctl.msg              = current_message;
    ctl.load_index       = held.desc_index;
    ctl.load_desc        = '{acklast: held.desc_acklast, nostart: held.desc_nostart,
                             read: held.desc_read, length: held.desc_length};

    if (held.action == ACT_LOAD) begin
      ctl.load = go && (OFS_W'(held.desc_index) < OFS_W'(MAX_MESSAGES));
    end else if (held.action == ACT_START) begin
      if (held.message_count == '0
          || OFS_W'(held.message_count) > OFS_W'(MAX_MESSAGES)) begin
        rsp_next.start_rejected = 1'b1;
      end else begin
        target_reg_next      = held.target_address;
        count_reg_next       = CNT_W'(held.message_count);
        current_message_next = '0;
        current_offset_next  = '0;
        busy_next            = 1'b1;
        rsp_next.gen_start   = 1'b1;
        ctl.restart          = go;
      end
    end else if (busy) begin
      case (held.action)
        ACT_START_SENT: begin
          rsp_next.command       = CMD_ADDR;
          rsp_next.data_byte     = {target_reg, cur.read};
          rsp_next.message_index = current_message[3:0];
          if (cur.read) begin
            rsp_next.ack_update = 1'b1;
            rsp_next.ack_enable = ack_rule(cur, nxt, current_offset, cm_w, cnt_w);
          end
        end
        ACT_TX_EMPTY: begin
          if (current_offset < cur.length) begin
            rsp_next.command       = CMD_SEND;
            rsp_next.message_index = current_message[3:0];
            rsp_next.byte_offset   = current_offset;
            current_offset_next    = off_bumped;
          end else if (more_msgs) begin
            current_message_next = current_message + CNT_W'(1);
            current_offset_next  = '0;
            ctl.advance          = go;
            if (!nxt.read && nxt.nostart) begin
              // Write continuation without a repeated start.
              if (nxt.length != '0) begin
                rsp_next.command       = CMD_SEND;
                rsp_next.message_index = current_message_next[3:0];
                current_offset_next    = 16'd1;
              end
            end else begin
              rsp_next.gen_start = 1'b1;
            end
          end else begin
            current_message_next     = count_reg;
            busy_next                = 1'b0;
            rsp_next.gen_stop        = 1'b1;
            rsp_next.transfer_done   = 1'b1;
          end
        end
        ACT_RX_BYTE: begin
          rsp_next.command       = CMD_STORE;
          rsp_next.data_byte     = held.rx_byte;
          rsp_next.message_index = current_message[3:0];
          rsp_next.byte_offset   = current_offset;
          current_offset_next    = off_bumped;
          if (off_bumped < cur.length) begin
            rsp_next.ack_update = 1'b1;
            rsp_next.ack_enable = ack_rule(cur, nxt, off_bumped, cm_w, cnt_w);
          end else if (more_msgs) begin
            current_message_next = current_message + CNT_W'(1);
            current_offset_next  = '0;
            ctl.advance          = go;
            if (nxt.read && nxt.nostart) begin
              rsp_next.ack_update = 1'b1;
              rsp_next.ack_enable = ack_rule(nxt, nx2, 16'd0,
                                             cm_w + OFS_W'(1), cnt_w);
            end else begin
              rsp_next.gen_start = 1'b1;
            end
          end else begin
            current_message_next   = count_reg;
            busy_next              = 1'b0;
            rsp_next.gen_stop      = 1'b1;
            rsp_next.transfer_done = 1'b1;
          end
        end
        ACT_BUS_ERROR: begin
          busy_next                = 1'b0;
          rsp_next.gen_stop        = 1'b1;
          rsp_next.transfer_done   = 1'b1;
          rsp_next.transfer_failed = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid      <= 1'b0;
      rsp_valid       <= 1'b0;
      target_reg      <= '0;
      count_reg       <= '0;
      current_message <= '0;
      current_offset  <= '0;
      busy            <= 1'b0;
    end else begin
      if (req_ready) begin
        held_valid <= req_valid;
      end
      if (adv) begin
        rsp_valid <= held_valid;
      end
      if (go) begin
        target_reg      <= target_reg_next;
        count_reg       <= count_reg_next;
        current_message <= current_message_next;
        current_offset  <= current_offset_next;
        busy            <= busy_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready) begin
      held <= req;
    end
    if (go) begin
      rsp <= rsp_next;
    end
  end

endmodule
